/* rtl/oriented_box_overlap_test_unit_defines.svh */
// Assertion macros for the oriented box overlap test unit.
`ifndef ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH

`ifndef SYNTH
// Generic property check, sampled on clk, off while reset is low.
`define OBB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Same-cycle implication check.
`define OBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define OBB_ASSERT(label, clk, rst_n, prop)
`define OBB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/obb_ovl_pkg.sv */
// Constants, widths and pair tables for the oriented box overlap test unit.
`default_nettype none

package obb_ovl_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NUM_COORDS  = 12;
    localparam int NUM_EDGES   = 4;
    localparam int NUM_PAIRS   = 10;
    localparam int NUM_STG     = 5;

    // packed input word, rounded up to whole bytes
    localparam int IN_DATA_W   = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;
    localparam int OUT_USER_W  = 1;

    localparam int EDGE_W      = COORD_WIDTH + 1;   // corner difference
    localparam int CTR_W       = COORD_WIDTH + 2;   // doubled center offset
    localparam int PROD_EE_W   = 2 * EDGE_W;
    localparam int PROD_DE_W   = CTR_W + EDGE_W;
    localparam int DOT_EE_W    = PROD_EE_W + 1;
    localparam int DOT_DE_W    = PROD_DE_W + 1;
    localparam int SUM_W       = DOT_EE_W + 2;      // four terms, >= DOT_DE_W

    // coordinate slots in the input word
    localparam int C_LAX = 0;
    localparam int C_LAY = 1;
    localparam int C_LBX = 2;
    localparam int C_LBY = 3;
    localparam int C_LCX = 4;
    localparam int C_LCY = 5;
    localparam int C_RAX = 6;
    localparam int C_RAY = 7;
    localparam int C_RBX = 8;
    localparam int C_RBY = 9;
    localparam int C_RCX = 10;
    localparam int C_RCY = 11;

    // edge-edge dots are symmetric: only the upper triangle is computed
    localparam int PAIR_LO [NUM_PAIRS] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int PAIR_HI [NUM_PAIRS] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
    localparam int PAIR_OF [NUM_EDGES][NUM_EDGES] = '{
        '{0, 1, 2, 3},
        '{1, 4, 5, 6},
        '{2, 5, 7, 8},
        '{3, 6, 8, 9}
    };

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [EDGE_W-1:0]      t_edge;
    typedef logic signed [CTR_W-1:0]       t_ctr;
    typedef logic signed [PROD_EE_W-1:0]   t_prod_ee;
    typedef logic signed [PROD_DE_W-1:0]   t_prod_de;
    typedef logic [DOT_EE_W-1:0]           t_adot_ee;
    typedef logic [DOT_DE_W-1:0]           t_adot_de;
    typedef logic [SUM_W-1:0]              t_sum;

endpackage

`default_nettype wire

/* rtl/oriented_box_overlap_test_unit.sv */
// Oriented box overlap test unit: pipelined 2D separating axis test.
// Each accepted input word passes through the registered stages (edges, products, magnitudes, sums, result) to m_axis.
// Throughput: one box pair per cycle unless m_axis stalls; each stage has its own valid bit, so bubbles
// close up and a stalled output only backs up the stages behind a full one.
// Result register is the last stage: a new word can enter while a result waits, until all stages are full.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data regs keep junk.
`default_nettype none
`include "oriented_box_overlap_test_unit_defines.svh"

module oriented_box_overlap_test_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // s_axis_tdata, lowest bits first: left_corner_a_x, left_corner_a_y,
    // left_corner_b_x, left_corner_b_y, left_corner_c_x, left_corner_c_y,
    // right_corner_a_x, right_corner_a_y, right_corner_b_x, right_corner_b_y,
    // right_corner_c_x, right_corner_c_y (16 bits each)
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [obb_ovl_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // m_axis_tdata: overlap in bit 0, zero fill above
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [obb_ovl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // m_axis_tuser: degenerate in bit 0
    output logic [obb_ovl_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import obb_ovl_pkg::*;

    // ---------------------------------------------------------------
    // Stage flow control: a stage loads when empty or when it drains.
    // ---------------------------------------------------------------
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] w_rdy;

    always_comb begin
        w_rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || m_axis_tready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NUM_STG; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = w_rdy[0];

    // ---------------------------------------------------------------
    // Stage 0: unpack corners, form edge vectors and doubled center
    // offset, flag zero-length edges.
    // ---------------------------------------------------------------
    t_coord c [NUM_COORDS];
    t_edge  ex [NUM_EDGES];
    t_edge  ey [NUM_EDGES];
    t_ctr   dx;
    t_ctr   dy;
    logic   deg;

    always_comb begin
        for (int n = 0; n < NUM_COORDS; n++) begin
            c[n] = s_axis_tdata[n*COORD_WIDTH +: COORD_WIDTH];
        end
        // edges leave the pivot corner B of each box
        ex[0] = EDGE_W'(c[C_LAX]) - EDGE_W'(c[C_LBX]);
        ey[0] = EDGE_W'(c[C_LAY]) - EDGE_W'(c[C_LBY]);
        ex[1] = EDGE_W'(c[C_LCX]) - EDGE_W'(c[C_LBX]);
        ey[1] = EDGE_W'(c[C_LCY]) - EDGE_W'(c[C_LBY]);
        ex[2] = EDGE_W'(c[C_RAX]) - EDGE_W'(c[C_RBX]);
        ey[2] = EDGE_W'(c[C_RAY]) - EDGE_W'(c[C_RBY]);
        ex[3] = EDGE_W'(c[C_RCX]) - EDGE_W'(c[C_RBX]);
        ey[3] = EDGE_W'(c[C_RCY]) - EDGE_W'(c[C_RBY]);
        // twice the center difference: sum of diagonal corners per box
        dx = (CTR_W'(c[C_LAX]) + CTR_W'(c[C_LCX]))
           - (CTR_W'(c[C_RAX]) + CTR_W'(c[C_RCX]));
        dy = (CTR_W'(c[C_LAY]) + CTR_W'(c[C_LCY]))
           - (CTR_W'(c[C_RAY]) + CTR_W'(c[C_RCY]));
        deg = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            if (ex[e] == '0 && ey[e] == '0) begin
                deg = 1'b1;
            end
        end
    end

    t_edge r_ex [NUM_EDGES];
    t_edge r_ey [NUM_EDGES];
    t_ctr  r_dx;
    t_ctr  r_dy;
    logic  r_deg0;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_ex   <= ex;
            r_ey   <= ey;
            r_dx   <= dx;
            r_dy   <= dy;
            r_deg0 <= deg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: products. Ten unique edge-edge pairs, four center-edge.
    // One 17x17 (or 18x17) multiplier per register.
    // ---------------------------------------------------------------
    t_prod_ee r_pex [NUM_PAIRS];
    t_prod_ee r_pey [NUM_PAIRS];
    t_prod_de r_pdx [NUM_EDGES];
    t_prod_de r_pdy [NUM_EDGES];
    logic     r_deg1;

    for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair_mul
        always_ff @(posedge i_clk) begin
            if (w_rdy[1]) begin
                r_pex[p] <= PROD_EE_W'(r_ex[PAIR_LO[p]]) * PROD_EE_W'(r_ex[PAIR_HI[p]]);
                r_pey[p] <= PROD_EE_W'(r_ey[PAIR_LO[p]]) * PROD_EE_W'(r_ey[PAIR_HI[p]]);
            end
        end
    end

    for (genvar a = 0; a < NUM_EDGES; a++) begin : g_ctr_mul
        always_ff @(posedge i_clk) begin
            if (w_rdy[1]) begin
                r_pdx[a] <= PROD_DE_W'(r_dx) * PROD_DE_W'(r_ex[a]);
                r_pdy[a] <= PROD_DE_W'(r_dy) * PROD_DE_W'(r_ey[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_deg1 <= r_deg0;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: finish dot products, take magnitudes.
    // ---------------------------------------------------------------
    logic signed [DOT_EE_W-1:0] dot_ee [NUM_PAIRS];
    logic signed [DOT_DE_W-1:0] dot_de [NUM_EDGES];
    t_adot_ee r_aee [NUM_PAIRS];
    t_adot_de r_ade [NUM_EDGES];
    logic     r_deg2;

    always_comb begin
        for (int p = 0; p < NUM_PAIRS; p++) begin
            dot_ee[p] = DOT_EE_W'(r_pex[p]) + DOT_EE_W'(r_pey[p]);
        end
        for (int a = 0; a < NUM_EDGES; a++) begin
            dot_de[a] = DOT_DE_W'(r_pdx[a]) + DOT_DE_W'(r_pdy[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int p = 0; p < NUM_PAIRS; p++) begin
                r_aee[p] <= dot_ee[p][DOT_EE_W-1] ? t_adot_ee'(-dot_ee[p])
                                                  : t_adot_ee'(dot_ee[p]);
            end
            for (int a = 0; a < NUM_EDGES; a++) begin
                r_ade[a] <= dot_de[a][DOT_DE_W-1] ? t_adot_de'(-dot_de[a])
                                                  : t_adot_de'(dot_de[a]);
            end
            r_deg2 <= r_deg1;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: per-axis projected extent (sum of four magnitudes).
    // ---------------------------------------------------------------
    t_sum     r_sum  [NUM_EDGES];
    t_adot_de r_dist [NUM_EDGES];
    logic     r_deg3;

    for (genvar a = 0; a < NUM_EDGES; a++) begin : g_axis_sum
        always_ff @(posedge i_clk) begin
            if (w_rdy[3]) begin
                r_sum[a]  <= SUM_W'(r_aee[PAIR_OF[a][0]]) + SUM_W'(r_aee[PAIR_OF[a][1]])
                           + SUM_W'(r_aee[PAIR_OF[a][2]]) + SUM_W'(r_aee[PAIR_OF[a][3]]);
                r_dist[a] <= r_ade[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_deg3 <= r_deg2;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: compare on every axis; equality is still overlap.
    // Degenerate boxes force overlap low.
    // ---------------------------------------------------------------
    logic [NUM_EDGES-1:0] sep;
    logic                 r_overlap;
    logic                 r_degen;

    always_comb begin
        for (int a = 0; a < NUM_EDGES; a++) begin
            sep[a] = SUM_W'(r_dist[a]) > r_sum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_overlap <= !r_deg3 && (sep == '0);
            r_degen   <= r_deg3;
        end
    end

    assign m_axis_tvalid = r_vld[NUM_STG-1];
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_overlap};
    assign m_axis_tuser  = r_degen;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `OBB_ASSERT_IMPL(a_degen_no_overlap, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], !m_axis_tdata[0])
    `OBB_ASSERT_IMPL(a_backpressure_full, i_clk, i_rst_n, !s_axis_tready, &r_vld)
    `OBB_ASSERT(a_stage_advance, i_clk, i_rst_n, (r_vld[0] && w_rdy[1]) |=> r_vld[1])
    `OBB_ASSERT(a_accept_enters, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> r_vld[0])

endmodule

`default_nettype wire

/* tb/box_overlap_checker.sv */
// Checker for the oriented box overlap test unit: predicts each result word and compares it.
module box_overlap_checker
    import obb_ovl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    // box pair word, lowest bits first: left A x/y, B x/y, C x/y, then right A, B, C
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    // overlap in bit 0
    input  logic [OUT_DATA_W-1:0] i_out_data,
    // degenerate in bit 0
    input  logic [OUT_USER_W-1:0] i_out_user,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic overlap;
        logic degenerate;
    } t_box_verdict;

    t_box_verdict verdict_q[$];
    t_box_verdict got_verdict;
    t_box_verdict want_verdict;
    int           fault_total = 0;
    int           words_pending = 0;
    int           results_seen = 0;

    assign o_fail_count = fault_total;
    assign o_pending    = words_pending;

    task automatic log_fault(input string what);
        $display("%0t ns checker: result %0d %s", $time, results_seen, what);
        fault_total = fault_total + 1;
    endtask

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Exact separating axis test on the edge directions of both boxes, unnormalized.
    function automatic t_box_verdict judge_pair(input logic [IN_DATA_W-1:0] word);
        longint       crd[NUM_COORDS];
        longint       ex[NUM_EDGES];
        longint       ey[NUM_EDGES];
        longint       dx, dy, span, gap;
        t_box_verdict v;
        for (int k = 0; k < NUM_COORDS; k++)
            crd[k] = longint'(t_coord'(word[k*COORD_WIDTH +: COORD_WIDTH]));
        ex[0] = crd[C_LAX] - crd[C_LBX];  ey[0] = crd[C_LAY] - crd[C_LBY];
        ex[1] = crd[C_LCX] - crd[C_LBX];  ey[1] = crd[C_LCY] - crd[C_LBY];
        ex[2] = crd[C_RAX] - crd[C_RBX];  ey[2] = crd[C_RAY] - crd[C_RBY];
        ex[3] = crd[C_RCX] - crd[C_RBX];  ey[3] = crd[C_RCY] - crd[C_RBY];
        dx = (crd[C_LAX] + crd[C_LCX]) - (crd[C_RAX] + crd[C_RCX]);
        dy = (crd[C_LAY] + crd[C_LCY]) - (crd[C_RAY] + crd[C_RCY]);
        v.overlap    = 1'b1;
        v.degenerate = 1'b0;
        for (int i = 0; i < NUM_EDGES; i++)
            if (ex[i] == 0 && ey[i] == 0)
                v.degenerate = 1'b1;
        if (v.degenerate) begin
            v.overlap = 1'b0;
            return v;
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            span = 0;
            for (int j = 0; j < NUM_EDGES; j++)
                span += magnitude(ex[j] * ex[i] + ey[j] * ey[i]);
            gap = magnitude(dx * ex[i] + dy * ey[i]);
            if (gap > span)
                v.overlap = 1'b0;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                got_verdict.overlap    = i_out_data[0];
                got_verdict.degenerate = i_out_user[0];
                if (verdict_q.size() == 0) begin
                    log_fault("arrived with nothing outstanding");
                end else begin
                    want_verdict = verdict_q.pop_front();
                    if (got_verdict.overlap != want_verdict.overlap)
                        log_fault($sformatf("bad overlap: got %0b want %0b",
                                            got_verdict.overlap, want_verdict.overlap));
                    if (got_verdict.degenerate != want_verdict.degenerate)
                        log_fault($sformatf("bad degenerate: got %0b want %0b",
                                            got_verdict.degenerate, want_verdict.degenerate));
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(judge_pair(i_in_data));
        end
        words_pending = verdict_q.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the oriented box overlap test bench: clock, reset, stimulus, ready pattern, verdict.
module tb_top;
    import obb_ovl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch with no word moving on either side before the run is declared hung.
    // A 57% receiver stall almost never holds that long.
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 20;   // pipeline is 5 deep, leave headroom
    localparam int RANDOM_PAIRS  = 250;  // per idling phase, three phases
    localparam int LEFT_SIDE     = C_LAX;
    localparam int RIGHT_SIDE    = C_RAX;

    // One box pair in word order: left A, B, C then right A, B, C, x before y.
    typedef int t_coord_set[NUM_COORDS];

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // s_axis_tdata, lowest bits first: 12 coordinates of 16 bits, left box then right box
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // m_axis_tdata: overlap in bit 0
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // m_axis_tuser: degenerate in bit 0
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int tx_idle_pct = 22;
    int rx_idle_pct = 57;
    int fail_count;
    int pending;
    int stall_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    oriented_box_overlap_test_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    box_overlap_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver backpressure: one draw per cycle against the current idle rate.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Hang detector: any accepted word on either side restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
    end

    function automatic int spread(input int reach);
        return int'($urandom_range(2 * reach)) - reach;
    endfunction

    function automatic bit in_range(input t_coord_set s);
        foreach (s[k])
            if (s[k] < -32768 || s[k] > 32767)
                return 1'b0;
        return 1'b1;
    endfunction

    // Box from pivot B and its edge vectors; which one lands on A is a coin toss,
    // so both corner orders get exercised.
    function automatic void place_box(inout t_coord_set s, input int side,
                                      input int bx, input int by,
                                      input int ux, input int uy,
                                      input int wx, input int wy);
        int t;
        if ($urandom_range(1)) begin
            t = ux; ux = wx; wx = t;
            t = uy; uy = wy; wy = t;
        end
        s[side + C_LBX] = bx;       s[side + C_LBY] = by;
        s[side + C_LAX] = bx + ux;  s[side + C_LAY] = by + uy;
        s[side + C_LCX] = bx + wx;  s[side + C_LCY] = by + wy;
    endfunction

    // Random pair mix:
    //   ~15% raw noise in every coordinate (skewed shapes, every bit toggles)
    //   ~15% touching pairs: same shape moved by one edge, sometimes nudged one LSB,
    //        which lands right on the equality boundary
    //   the rest true rectangles at several scales with random placement,
    //   and ~12% of all pairs get one edge collapsed to zero.
    function automatic t_coord_set random_pair();
        t_coord_set s;
        int kind, reach, m, ux, uy, wx, wy, vx, vy, bx, by, ox, oy, sz;
        kind = $urandom_range(99);
        if (kind < 15) begin
            foreach (s[k])
                s[k] = int'($urandom_range(65535)) - 32768;
            return s;
        end
        do begin
            case ($urandom_range(3))
                0:       reach = 4;
                1:       reach = 60;
                2:       reach = 1200;
                default: reach = 7000;
            endcase
            ux = spread(reach);
            uy = spread(reach);
            if (ux == 0 && uy == 0)
                ux = reach;
            m = int'($urandom_range(3)) + 1;
            if ($urandom_range(1))
                m = -m;
            wx = -uy * m;
            wy = ux * m;
            bx = spread(16000);
            by = spread(16000);
            place_box(s, LEFT_SIDE, bx, by, ux, uy, wx, wy);
            if (kind < 30) begin
                if ($urandom_range(1)) begin
                    ox = ux; oy = uy;
                end else begin
                    ox = wx; oy = wy;
                end
                if ($urandom_range(1)) begin
                    ox = -ox; oy = -oy;
                end
                if ($urandom_range(1)) begin
                    ox += spread(1);
                    oy += spread(1);
                end
                place_box(s, RIGHT_SIDE, bx + ox, by + oy, ux, uy, wx, wy);
            end else begin
                vx = spread(reach);
                vy = spread(reach);
                if (vx == 0 && vy == 0)
                    vy = reach;
                m = int'($urandom_range(3)) + 1;
                if ($urandom_range(1))
                    m = -m;
                sz = (ux < 0 ? -ux : ux) + (uy < 0 ? -uy : uy)
                   + (wx < 0 ? -wx : wx) + (wy < 0 ? -wy : wy)
                   + (vx < 0 ? -vx : vx) + (vy < 0 ? -vy : vy);
                place_box(s, RIGHT_SIDE, bx + spread(sz), by + spread(sz),
                          vx, vy, -vy * m, vx * m);
            end
        end while (!in_range(s));
        if (kind >= 88) begin
            case ($urandom_range(3))
                0:       begin s[C_LAX] = s[C_LBX]; s[C_LAY] = s[C_LBY]; end
                1:       begin s[C_LCX] = s[C_LBX]; s[C_LCY] = s[C_LBY]; end
                2:       begin s[C_RAX] = s[C_RBX]; s[C_RAY] = s[C_RBY]; end
                default: begin s[C_RCX] = s[C_RBX]; s[C_RCY] = s[C_RBY]; end
            endcase
        end
        return s;
    endfunction

    // Send one pair; called at a rising edge, returns at the edge that takes the word.
    // Ready is looked at on the falling edge, where it has settled for the next edge.
    task automatic offer_pair(input t_coord_set s);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        foreach (s[k])
            word[k*COORD_WIDTH +: COORD_WIDTH] = s[k][COORD_WIDTH-1:0];
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {6{$urandom()}};   // junk while idle
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs, sender 22% idle, receiver 57% idle.
        // Order: left A, B, C then right A, B, C, each as x, y.
        offer_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});              // all edges zero
        offer_pair('{0, 0, 0, 0, 10, 0, 0, 10, 0, 0, 10, 0});           // left A on B
        offer_pair('{0, 10, 0, 0, 0, 0, 0, 10, 0, 0, 10, 0});           // left C on B
        offer_pair('{0, 10, 0, 0, 10, 0, 5, 5, 5, 5, 15, 5});           // right A on B
        offer_pair('{0, 10, 0, 0, 10, 0, 5, 15, 5, 5, 5, 5});           // right C on B
        offer_pair('{0, 10, 0, 0, 10, 0, 0, 10, 0, 0, 10, 0});          // identical boxes
        offer_pair('{0, 10, 0, 0, 10, 0, 10, 10, 10, 0, 20, 0});        // edges touch: tie
        offer_pair('{0, 10, 0, 0, 10, 0, 11, 10, 11, 0, 21, 0});        // one LSB apart
        offer_pair('{103, 104, 100, 100, 92, 106,
                     106, 108, 103, 104, 95, 110});                     // rotated, touching
        offer_pair('{103, 104, 100, 100, 92, 106,
                     107, 108, 104, 104, 96, 110});                     // rotated, just apart
        offer_pair('{32767, 32767, -32768, 32767, -32768, -32768,
                     -32768, -32768, 32767, -32768, 32767, 32767});     // full-range boxes
        offer_pair('{32767, 32752, 32767, 32767, 32752, 32767,
                     -32768, -32753, -32768, -32768, -32753, -32768});  // opposite far corners
        offer_pair('{10, 0, 0, 0, 5, 5, 20, 3, 12, 1, 14, 9});          // skewed, not square
        offer_pair('{1, -20, 0, -20, 0, 20, -20, 1, -20, 0, 20, 0});    // thin slivers cross
        offer_pair('{21845, -21846, -21846, 21845, 21845, 21845,
                     -21846, -21846, 21845, -21846, -21846, 21845});    // alternating bits
        offer_pair('{-1000, 1000, -1000, -1000, 1000, -1000,
                     0, 3, 0, 0, 3, 0});                                // small inside big
        offer_pair('{0, 0, 0, -50, -50, 0, -30, 30, -30, -30, 30, -30}); // skewed box vs square
        offer_pair('{12{32767}});                                       // all max, degenerate
        offer_pair('{12{-32768}});                                      // all min, degenerate

        // Random pairs in three idling phases: sender light / receiver heavy,
        // then swapped, then both sides flat out.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 22; rx_idle_pct = 57; end
                1:       begin tx_idle_pct = 57; rx_idle_pct = 22; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            repeat (RANDOM_PAIRS)
                offer_pair(random_pair());
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every expected result back, then let the pipeline settle.
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
